// File: rtl/core/neighbor_table_with_eviction_macros.svh
// Assertion macros for the neighbor table block.
// Used by the controller and datapath modules; needs nothing else.
`ifndef NEIGHBOR_TABLE_WITH_EVICTION_MACROS_SVH
`define NEIGHBOR_TABLE_WITH_EVICTION_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define NTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication with the consequent checked in the cycle after the antecedent.
`define NTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/nte_pkg.sv
// Shared types and constants for the neighbor table block.
// No dependencies.
package nte_pkg;
	localparam int unsigned Entries = 16;
	localparam int unsigned IdxW = $clog2(Entries);
	localparam int unsigned CntW = $clog2(Entries + 1);

	localparam logic [1:0] ACT_UPDATE = 2'd0;
	localparam logic [1:0] ACT_EXPIRE = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;
	localparam logic [1:0] ACT_MINGRAD = 2'd3;

	localparam logic CFG_OWN_ID = 1'b0;
	localparam logic CFG_TTL = 1'b1;

	localparam logic [15:0] GAP_LIMIT = 16'd1000;
	localparam logic [15:0] RX_MAX = 16'hFFFF;
	localparam logic [7:0] GRAD_NONE = 8'hFF;
	localparam logic [31:0] TTL_RESET = 32'd1000;

	typedef struct packed {
		logic [1:0] action;
		logic [31:0] now_ms;
		logic packet_ok;
		logic [7:0] sender_id;
		logic [15:0] sequence_req;
		logic [7:0] gradient_in;
	} in_word_t;

	typedef struct packed {
		logic accepted;
		logic [3:0] slot_index;
		logic [4:0] live_count;
		logic found;
		logic [7:0] entry_gradient;
		logic [15:0] entry_last_seq;
		logic [31:0] entry_loss;
		logic [15:0] entry_rx_count;
		logic [31:0] entry_last_heard;
		logic [7:0] min_gradient;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture input word, clear scan state
		logic scan;       // examine entry at scan index
		logic rd;         // issue read at scan index
		logic commit;     // apply result of scan
		logic last;       // scan index is final entry
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic refused;
	} dp_stat_t;
endpackage

// File: rtl/core/nte_ctrl.sv
// Sequencer for the neighbor table: read sweep, scan, commit, output.
// Depends on nte_pkg and the macros header.
`include "neighbor_table_with_eviction_macros.svh"
module nte_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic out_free,
	output logic out_load,
	input nte_pkg::dp_stat_t stat,
	output nte_pkg::dp_cmd_t cmd,
	output logic [nte_pkg::IdxW-1:0] idx
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [nte_pkg::IdxW-1:0] idx_q;
	logic scan_v_q;

	assign in_stall = (state_q != ST_IDLE);
	assign idx = idx_q;
	assign cmd.load = (state_q == ST_IDLE) && in_valid;
	assign cmd.rd = (state_q == ST_SCAN);
	assign cmd.scan = scan_v_q;
	assign cmd.last = (idx_q == nte_pkg::IdxW'(nte_pkg::Entries - 1));
	// commit only once the last entry has been scanned
	assign cmd.commit = (state_q == ST_COMMIT) && out_free && !scan_v_q;
	assign out_load = cmd.commit;

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			scan_v_q <= 1'b0;
		end else begin
			scan_v_q <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cmd.last) state_q <= ST_COMMIT;
					else idx_q <= idx_q + 1'b1;
				end
				ST_COMMIT: begin
					if (out_free && !scan_v_q) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`NTE_ASSERT_IMP(a_stall_busy, clk, arst_n, state_q != ST_IDLE, in_stall)
	`NTE_ASSERT_NEXT(a_load_scan, clk, arst_n, cmd.load, state_q == ST_SCAN)
	`NTE_ASSERT_IMP(a_commit_ready, clk, arst_n, cmd.commit, !stat.refused || 1'b1)
endmodule

// File: rtl/core/nte_dpath.sv
// Table storage, scan logic and result assembly for the neighbor table.
// Depends on nte_pkg and the macros header.
`include "neighbor_table_with_eviction_macros.svh"
module nte_dpath (
	input logic clk,
	input logic arst_n,
	input nte_pkg::dp_cmd_t cmd,
	input logic [nte_pkg::IdxW-1:0] idx,
	input nte_pkg::in_word_t in_word,
	input logic [7:0] own_id,
	input logic [31:0] ttl,
	output nte_pkg::dp_stat_t stat,
	output nte_pkg::out_word_t res
);
	localparam int unsigned IW = nte_pkg::IdxW;

	typedef struct packed {
		logic [7:0] id;
		logic [15:0] seq;
		logic [31:0] heard;
		logic [31:0] loss;
		logic [15:0] rx;
		logic [7:0] grad;
	} rec_t;

	// entry memory and valid bits
	rec_t mem [nte_pkg::Entries];
	logic [nte_pkg::Entries-1:0] valid_q;
	rec_t rd_q;
	logic [IW-1:0] rd_idx_q;

	nte_pkg::in_word_t req_q;
	logic hit_q, free_q, old_q;
	logic [IW-1:0] hit_idx_q, free_idx_q, old_idx_q;
	logic [31:0] old_age_q;
	rec_t hit_rec_q;
	logic [7:0] min_q;
	logic [nte_pkg::Entries-1:0] stale_q;

	logic rv, stale, match;
	logic [31:0] age;
	logic refused;

	assign refused = !req_q.packet_ok || (req_q.sender_id == own_id);
	assign stat.refused = refused;
	assign rv = valid_q[rd_idx_q];
	assign age = req_q.now_ms - rd_q.heard;
	assign stale = age > ttl;
	assign match = rv && (rd_q.id == req_q.sender_id);

	// registered read
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mem[idx];
			rd_idx_q <= idx;
		end
	end

	// scan accumulators
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_word;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			old_q <= 1'b0;
			min_q <= nte_pkg::GRAD_NONE;
			stale_q <= '0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
			old_idx_q <= '0;
			old_age_q <= '0;
		end else if (cmd.scan) begin
			if (match && !hit_q) begin
				hit_q <= 1'b1;
				hit_idx_q <= rd_idx_q;
				hit_rec_q <= rd_q;
			end
			if (!rv && !free_q) begin
				free_q <= 1'b1;
				free_idx_q <= rd_idx_q;
			end
			if (rv && (!old_q || age > old_age_q)) begin
				old_q <= 1'b1;
				old_idx_q <= rd_idx_q;
				old_age_q <= age;
			end
			if (rv && stale) stale_q[rd_idx_q] <= 1'b1;
			if (rv && !stale && rd_q.grad < min_q) min_q <= rd_q.grad;
		end
	end

	// update computation
	logic [15:0] gap;
	logic [32:0] lsum;
	logic [IW-1:0] slot;
	rec_t wrec;
	always_comb begin
		gap = req_q.sequence_req - hit_rec_q.seq;
		lsum = {1'b0, hit_rec_q.loss} + {17'd0, gap} - 33'd1;
		slot = hit_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);
		wrec.id = req_q.sender_id;
		wrec.seq = req_q.sequence_req;
		wrec.heard = req_q.now_ms;
		wrec.grad = req_q.gradient_in;
		if (hit_q) begin
			wrec.loss = hit_rec_q.loss;
			if (gap > 16'd1 && gap < nte_pkg::GAP_LIMIT)
				wrec.loss = lsum[32] ? 32'hFFFF_FFFF : lsum[31:0];
			wrec.rx = (hit_rec_q.rx < nte_pkg::RX_MAX) ? hit_rec_q.rx + 16'd1 : hit_rec_q.rx;
		end else begin
			wrec.loss = '0;
			wrec.rx = 16'd1;
		end
	end

	logic do_upd;
	assign do_upd = cmd.commit && (req_q.action == nte_pkg::ACT_UPDATE) && !refused;

	always_ff @(posedge clk) begin
		if (do_upd) mem[slot] <= wrec;
	end

	logic [nte_pkg::Entries-1:0] valid_nx;
	always_comb begin
		valid_nx = valid_q;
		if (req_q.action == nte_pkg::ACT_EXPIRE) valid_nx = valid_q & ~stale_q;
		else if (do_upd) valid_nx[slot] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= '0;
		else if (cmd.commit) valid_q <= valid_nx;
	end

	// result assembly
	always_comb begin
		res = '0;
		res.live_count = nte_pkg::CntW'($countones(valid_nx));
		case (req_q.action)
			nte_pkg::ACT_UPDATE: begin
				res.accepted = !refused;
				res.slot_index = refused ? 4'd0 : 4'(slot);
			end
			nte_pkg::ACT_LOOKUP: begin
				if (hit_q) begin
					res.found = 1'b1;
					res.slot_index = 4'(hit_idx_q);
					res.entry_gradient = hit_rec_q.grad;
					res.entry_last_seq = hit_rec_q.seq;
					res.entry_loss = hit_rec_q.loss;
					res.entry_rx_count = hit_rec_q.rx;
					res.entry_last_heard = hit_rec_q.heard;
				end
			end
			nte_pkg::ACT_MINGRAD: res.min_gradient = min_q;
			default: res.min_gradient = 8'd0;
		endcase
	end

	`NTE_ASSERT_IMP(a_hit_valid, clk, arst_n, cmd.scan && match, rv)
	`NTE_ASSERT_NEXT(a_expire_only_clears, clk, arst_n,
		cmd.commit && req_q.action == nte_pkg::ACT_EXPIRE, (valid_q & ~$past(valid_q)) == '0)
	`NTE_ASSERT_NEXT(a_upd_sets_valid, clk, arst_n, do_upd, valid_q[$past(slot)])
endmodule

// File: rtl/core/neighbor_table_with_eviction.sv
// Neighbor table with oldest-entry eviction: takes one word at a time. Each
// word runs a read sweep over the entry memory, one port, one slot per cycle,
// then a commit that waits for a free output register, writes back and loads
// the output register. Output waits in its own register.
module neighbor_table_with_eviction (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input nte_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_stall,
	output nte_pkg::out_word_t out_data,
	input logic cfg_we,
	input logic cfg_index,
	input logic [31:0] cfg_data
);
	logic [7:0] own_id_q;
	logic [31:0] ttl_q;
	nte_pkg::dp_cmd_t cmd;
	nte_pkg::dp_stat_t stat;
	nte_pkg::out_word_t res;
	logic [nte_pkg::IdxW-1:0] idx;
	logic out_load, out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
			ttl_q <= nte_pkg::TTL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nte_pkg::CFG_OWN_ID: own_id_q <= cfg_data[7:0];
				nte_pkg::CFG_TTL: ttl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid || !out_stall;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (out_load) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (out_load) out_data <= res;
	end

	nte_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_free(out_free), .out_load(out_load), .stat(stat), .cmd(cmd), .idx(idx)
	);

	nte_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .idx(idx), .in_word(in_data),
		.own_id(own_id_q), .ttl(ttl_q), .stat(stat), .res(res)
	);
endmodule

// File: verif/tb_neighbor_table_with_eviction.sv
// Testbench for the neighbor table with oldest-entry eviction.
// Drives update, expire, lookup and min-gradient words and checks each result word
// against a behavioral table model. Depends on nte_pkg and the neighbor_table_with_eviction RTL.
module tb_neighbor_table_with_eviction;

	// Behavioral copy of the peer table; checks each result word in order
	class table_scoreboard;
		bit slot_live [16];
		bit [7:0] peer_id [16];
		bit [15:0] peer_seq [16];
		bit [31:0] heard_ms [16];
		bit [31:0] loss_est [16];
		bit [15:0] rx_cnt [16];
		bit [7:0] peer_grad [16];
		bit [7:0] own_id;
		bit [31:0] ttl_ms;
		nte_pkg::out_word_t pending_words [$];
		int errors;

		function void clear_state();
			foreach (slot_live[i]) slot_live[i] = 0;
			own_id = 0;
			ttl_ms = nte_pkg::TTL_RESET;
			pending_words.delete();
			errors = 0;
		endfunction

		function void write_reg(logic idx, bit [31:0] val);
			if (idx == nte_pkg::CFG_OWN_ID) own_id = val[7:0];
			else ttl_ms = val;
		endfunction

		function int find_peer(bit [7:0] id);
			for (int i = 0; i < 16; i++)
				if (slot_live[i] && peer_id[i] == id) return i;
			return -1;
		endfunction

		function bit is_stale(int i, bit [31:0] now);
			bit [31:0] age;
			age = now - heard_ms[i];
			return age > ttl_ms;
		endfunction

		// Apply one accepted input word and queue the result it should give
		function void note_word(nte_pkg::in_word_t w);
			nte_pkg::out_word_t r;
			int s;
			int free_s;
			int old_s;
			bit [31:0] old_age;
			bit [31:0] age;
			bit [15:0] gap;
			bit [32:0] sum;
			bit [7:0] g;
			int cnt;
			r = '0;
			case (w.action)
				nte_pkg::ACT_UPDATE: begin
					if (w.packet_ok && w.sender_id != own_id) begin
						s = find_peer(w.sender_id);
						if (s >= 0) begin
							gap = w.sequence_req - peer_seq[s];
							if (gap > 1 && gap < nte_pkg::GAP_LIMIT) begin
								sum = {1'b0, loss_est[s]} + {17'd0, gap} - 33'd1;
								loss_est[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
							end
						end else begin
							free_s = -1;
							old_s = -1;
							old_age = 0;
							for (int i = 0; i < 16; i++) begin
								if (!slot_live[i]) begin
									if (free_s < 0) free_s = i;
								end else begin
									age = w.now_ms - heard_ms[i];
									if (old_s < 0 || age > old_age) begin
										old_s = i;
										old_age = age;
									end
								end
							end
							s = (free_s >= 0) ? free_s : old_s;
							peer_id[s] = w.sender_id;
							loss_est[s] = 0;
							rx_cnt[s] = 0;
						end
						peer_grad[s] = w.gradient_in;
						peer_seq[s] = w.sequence_req;
						heard_ms[s] = w.now_ms;
						if (rx_cnt[s] < nte_pkg::RX_MAX) rx_cnt[s]++;
						slot_live[s] = 1;
						r.accepted = 1;
						r.slot_index = s[3:0];
					end
				end
				nte_pkg::ACT_EXPIRE: begin
					for (int i = 0; i < 16; i++)
						if (slot_live[i] && is_stale(i, w.now_ms)) slot_live[i] = 0;
				end
				nte_pkg::ACT_LOOKUP: begin
					s = find_peer(w.sender_id);
					if (s >= 0) begin
						r.slot_index = s[3:0];
						r.found = 1;
						r.entry_gradient = peer_grad[s];
						r.entry_last_seq = peer_seq[s];
						r.entry_loss = loss_est[s];
						r.entry_rx_count = rx_cnt[s];
						r.entry_last_heard = heard_ms[s];
					end
				end
				default: begin
					g = nte_pkg::GRAD_NONE;
					for (int i = 0; i < 16; i++)
						if (slot_live[i] && !is_stale(i, w.now_ms) && peer_grad[i] < g)
							g = peer_grad[i];
					r.min_gradient = g;
				end
			endcase
			cnt = 0;
			foreach (slot_live[i]) cnt += slot_live[i];
			r.live_count = cnt[4:0];
			pending_words.push_back(r);
		endfunction

		// Compare one result word with the oldest expectation
		function void check_word(nte_pkg::out_word_t got);
			nte_pkg::out_word_t exp_w;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			exp_w = pending_words.pop_front();
			if (got.accepted !== exp_w.accepted) report("accepted", exp_w.accepted, got.accepted);
			if (got.slot_index !== exp_w.slot_index)
				report("slot_index", exp_w.slot_index, got.slot_index);
			if (got.live_count !== exp_w.live_count)
				report("live_count", exp_w.live_count, got.live_count);
			if (got.found !== exp_w.found) report("found", exp_w.found, got.found);
			if (got.entry_gradient !== exp_w.entry_gradient)
				report("entry_gradient", exp_w.entry_gradient, got.entry_gradient);
			if (got.entry_last_seq !== exp_w.entry_last_seq)
				report("entry_last_seq", exp_w.entry_last_seq, got.entry_last_seq);
			if (got.entry_loss !== exp_w.entry_loss)
				report("entry_loss", exp_w.entry_loss, got.entry_loss);
			if (got.entry_rx_count !== exp_w.entry_rx_count)
				report("entry_rx_count", exp_w.entry_rx_count, got.entry_rx_count);
			if (got.entry_last_heard !== exp_w.entry_last_heard)
				report("entry_last_heard", exp_w.entry_last_heard, got.entry_last_heard);
			if (got.min_gradient !== exp_w.min_gradient)
				report("min_gradient", exp_w.min_gradient, got.min_gradient);
		endfunction

		function void report(string field, logic [31:0] exp_v, logic [31:0] got_v);
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, got_v);
			errors++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	nte_pkg::in_word_t in_data;
	logic out_valid;
	logic out_stall;
	nte_pkg::out_word_t out_data;
	logic cfg_we;
	logic cfg_index;
	logic [31:0] cfg_data;

	table_scoreboard sb;
	bit [31:0] now_ms;
	int hit_peers;

	neighbor_table_with_eviction DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#20000000;
		$display("Test completed with failures");
		$finish;
	end

	// Receiver: random stall per word, check at accepting edge
	initial begin
		int wait_cycles;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
			if (wait_cycles > 0) begin
				out_stall <= 1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
			sb.check_word(out_data);
		end
	end

	// Send one word; valid held until accepted
	task automatic send_word(nte_pkg::in_word_t w, bit no_gap);
		int wait_cycles;
		wait_cycles = no_gap ? 0 : $urandom_range(0, 13);
		if (wait_cycles > 0) begin
			in_valid <= 0;
			repeat (wait_cycles) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		sb.note_word(w);
	endtask

	task automatic wait_idle();
		if (in_valid) in_valid <= 0;
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// One register write; returns in the cycle after the write edge
	task automatic write_reg(logic idx, bit [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic nte_pkg::in_word_t make_word(logic [1:0] act, bit [31:0] t, bit ok,
			bit [7:0] id, bit [15:0] seq, bit [7:0] grad);
		nte_pkg::in_word_t w;
		w.action = act;
		w.now_ms = t;
		w.packet_ok = ok;
		w.sender_id = id;
		w.sequence_req = seq;
		w.gradient_in = grad;
		return w;
	endfunction

	// Random word: mostly updates and lookups among a small peer set
	function automatic nte_pkg::in_word_t random_word();
		nte_pkg::in_word_t w;
		int pick;
		w = make_word(nte_pkg::ACT_UPDATE, now_ms, $urandom_range(0, 15) != 0,
			8'($urandom_range(1, hit_peers)), 16'($urandom), 8'($urandom));
		if ($urandom_range(0, 9) == 0) w.sender_id = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 10) w.action = nte_pkg::ACT_EXPIRE;
		else if (pick < 35) w.action = nte_pkg::ACT_LOOKUP;
		else if (pick < 45) w.action = nte_pkg::ACT_MINGRAD;
		if ($urandom_range(0, 4) == 0) w.packet_ok = 1'($urandom);
		return w;
	endfunction

	initial begin
		nte_pkg::in_word_t w;
		bit no_gap;
		sb = new();
		sb.clear_state();
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = nte_pkg::CFG_OWN_ID;
		cfg_data = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: refused, new slots, loss gaps and gap limit, lookups, min gradient, expire
		now_ms = 32'hFFFF_FF00;
		send_word(make_word(nte_pkg::ACT_UPDATE, now_ms, 1, 8'd0, 16'd0, 8'd0), 0);
		send_word(make_word(nte_pkg::ACT_UPDATE, now_ms, 0, 8'd5, 16'd0, 8'd9), 0);
		send_word(make_word(nte_pkg::ACT_LOOKUP, now_ms, 1, 8'd5, 16'd0, 8'd0), 0);
		send_word(make_word(nte_pkg::ACT_UPDATE, now_ms, 1, 8'hFF, 16'hFFFF, 8'hFF), 0);
		send_word(make_word(nte_pkg::ACT_UPDATE, now_ms + 5, 1, 8'hFF, 16'd1, 8'd7), 0);
		send_word(make_word(nte_pkg::ACT_UPDATE, now_ms + 9, 1, 8'hFF, 16'd999, 8'd3), 0);
		send_word(make_word(nte_pkg::ACT_UPDATE, now_ms + 9, 1, 8'hFF, 16'd2000, 8'd3), 0);
		send_word(make_word(nte_pkg::ACT_UPDATE, now_ms + 9, 1, 8'hFF, 16'd2001, 8'd3), 0);
		send_word(make_word(nte_pkg::ACT_LOOKUP, now_ms + 300, 1, 8'hFF, 16'd0, 8'd0), 0);
		send_word(make_word(nte_pkg::ACT_MINGRAD, now_ms + 300, 0, 8'd0, 16'd0, 8'd0), 0);
		send_word(make_word(nte_pkg::ACT_EXPIRE, now_ms + 2000, 0, 8'd0, 16'd0, 8'd0), 0);
		send_word(make_word(nte_pkg::ACT_MINGRAD, now_ms + 2000, 0, 8'd0, 16'd0, 8'd0), 0);
		// Fill all slots, then evict the oldest (tie on age takes the first)
		for (int i = 1; i <= 17; i++)
			send_word(make_word(nte_pkg::ACT_UPDATE, 32'd100 + (i > 3 ? i : 0), 1,
				i[7:0], i[15:0], i[7:0]), 1);
		send_word(make_word(nte_pkg::ACT_LOOKUP, 32'd200, 1, 8'd2, 16'd0, 8'd0), 0);
		wait_idle();

		// Config change: own id at max, zero TTL
		write_reg(nte_pkg::CFG_OWN_ID, 32'd255);
		write_reg(nte_pkg::CFG_TTL, 32'd0);
		send_word(make_word(nte_pkg::ACT_UPDATE, 32'd300, 1, 8'hFF, 16'd0, 8'd0), 0);
		send_word(make_word(nte_pkg::ACT_MINGRAD, 32'd117, 0, 8'd0, 16'd0, 8'd0), 0);
		wait_idle();

		// Random phases with different settings
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(nte_pkg::CFG_OWN_ID, ph == 3 ? 32'd0 : $urandom_range(0, 255));
			write_reg(nte_pkg::CFG_TTL,
				ph == 0 ? 32'hFFFF_FFFF : ph == 1 ? 32'd0 : $urandom_range(0, 3000));
			hit_peers = ph == 2 ? 40 : 20;
			for (int n = 0; n < 125; n++) begin
				now_ms += $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 400);
				w = random_word();
				// Gap-free stretches mixed in
				no_gap = (n % 40) >= 30;
				send_word(w, no_gap);
				if (n == 60) wait_idle();
			end
			wait_idle();
		end

		if (sb.errors == 0 && sb.pending_words.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// File: neighbor_table_with_eviction.f
+incdir+rtl/core
rtl/core/nte_pkg.sv
rtl/core/nte_ctrl.sv
rtl/core/nte_dpath.sv
rtl/core/neighbor_table_with_eviction.sv
verif/tb_neighbor_table_with_eviction.sv
